/* rtl/core/ssa_pkg.sv */
// Package for the stack sample aggregator: sizes, codes and shared types.
// Depends on nothing; the top level and ssa_ctrl import it, ssa_ram does not.
`default_nettype none
package ssa_pkg;

    localparam int FRAME_SLOTS   = 32;
    localparam int TABLE_ENTRIES = 256;
    localparam int FRAME_W       = 5;
    localparam int ENTRY_W       = 8;
    localparam int STORE_AW      = ENTRY_W + FRAME_W;
    localparam int STORE_DEPTH   = TABLE_ENTRIES * FRAME_SLOTS;
    localparam int SLOT_CNT_W    = 6;
    localparam int USED_W        = 9;
    localparam int IN_DATA_W     = 144;
    localparam int OUT_DATA_W    = 152;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_MERGED  = 3'd0,
        ST_ADDED   = 3'd1,
        ST_SKIPPED = 3'd2,
        ST_DROPPED = 3'd3,
        ST_READ    = 3'd4,
        ST_BADIDX  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_CNT_RD,
        S_CNT_UPD,
        S_COPY,
        S_RD_ADDR,
        S_RD_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [63:0]         wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        logic               wr_en;
        logic [ENTRY_W-1:0] addr;
        logic [63:0]        wr_data;
        logic               rd_en;
    } count_req_t;

endpackage
`default_nettype wire

/* rtl/core/stack_sample_aggregator_top.sv */
// Top level of the stack sample aggregator: stream ports, mode register,
// stack store and count RAMs. Depends on ssa_pkg, ssa_ram and ssa_ctrl.
//
// Use: samples arrive on the slave stream, one return address per transfer,
// with tuser = 0 and tlast on the final frame, which also carries the weight.
// tuser = 1 reads one stored frame and the entry count, tuser = 2 clears the
// table, tuser = 3 is ignored. Each finished sample or read yields one
// transfer on the master stream; tuser there is the status code.
// Non-last frames are accepted whenever the block is idle, even while a result
// waits for the receiver. A last frame scans the table with one comparator,
// reading then comparing one stored frame at a time, then either appends a
// new stack by copying the staged slots or updates a count by a read and
// a write. The scan is bounded by the single-read-port stack RAM.
// When the receiver stalls, the result is held in the output register and
// the block stops taking items only once a second result is ready.
// Reset clears the mode register (count mode), the table fill count and the
// staging fill count; RAM contents are not cleared and need no clearing pass.
// The mode register is written on the cfg channel, which is always ready.
`default_nettype none
module stack_sample_aggregator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [0:0]                     cfg_data,   // wait_mode
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // frame_value [63:0], weight [127:64], entry_index [135:128],
    // frame_index [140:136], zero fill above
    input  wire logic [ssa_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                     s_tuser,    // kind
    input  wire logic                           s_tlast,    // last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // slot_index [7:0], read_frame [71:8], count [135:72],
    // entries_in_use [144:136], zero fill above
    output logic [ssa_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [2:0]                          m_tuser     // status
);
    import ssa_pkg::*;

    logic        wait_mode_reg;
    store_req_t  store_req;
    count_req_t  count_req;
    logic [63:0] store_q;
    logic [63:0] count_q;
    logic [ENTRY_W-1:0] out_slot;
    logic [63:0] out_frame;
    logic [63:0] out_count;
    logic [USED_W-1:0] out_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            wait_mode_reg <= cfg_data[0];
        end
    end

    ssa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .wait_mode  (wait_mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_frame   (s_tdata[63:0]),
        .in_last    (s_tlast),
        .in_weight  (s_tdata[127:64]),
        .in_entry   (s_tdata[135:128]),
        .in_fidx    (s_tdata[140:136]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_frame  (out_frame),
        .out_count  (out_count),
        .out_used   (out_used),
        .store_req  (store_req),
        .store_q    (store_q),
        .count_req  (count_req),
        .count_q    (count_q)
    );

    // Stack store: one row of frame slots per table entry.
    ssa_ram #(
        .WIDTH (64),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_req.wr_en),
        .wr_addr (store_req.wr_addr),
        .wr_data (store_req.wr_data),
        .rd_en   (store_req.rd_en),
        .rd_addr (store_req.rd_addr),
        .rd_data (store_q)
    );

    ssa_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_ENTRIES)
    ) u_counts (
        .clk     (clk),
        .wr_en   (count_req.wr_en),
        .wr_addr (count_req.addr),
        .wr_data (count_req.wr_data),
        .rd_en   (count_req.rd_en),
        .rd_addr (count_req.addr),
        .rd_data (count_q)
    );

    assign m_tdata = {7'd0, out_used, out_count, out_frame, out_slot};

endmodule
`default_nettype wire

/* rtl/core/ssa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for the stack store and the entry counts.
`default_nettype none
module ssa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ssa_ctrl.sv */
// Sequencer of the aggregator: staging stack, table scan with one shared
// comparator, saturating count update, append copy and result register.
// Depends on ssa_pkg; drives the two RAMs instantiated in the top level.
`default_nettype none
module ssa_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wait_mode,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     in_kind,
    input  wire logic [63:0]                    in_frame,
    input  wire logic                           in_last,
    input  wire logic [63:0]                    in_weight,
    input  wire logic [ssa_pkg::ENTRY_W-1:0]    in_entry,
    input  wire logic [ssa_pkg::FRAME_W-1:0]    in_fidx,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          out_status,
    output logic [ssa_pkg::ENTRY_W-1:0]         out_slot,
    output logic [63:0]                         out_frame,
    output logic [63:0]                         out_count,
    output logic [ssa_pkg::USED_W-1:0]          out_used,
    output ssa_pkg::store_req_t                 store_req,
    input  wire logic [63:0]                    store_q,
    output ssa_pkg::count_req_t                 count_req,
    input  wire logic [63:0]                    count_q
);
    import ssa_pkg::*;

    state_t                state_reg, state_next;
    logic [SLOT_CNT_W-1:0] slot_cnt_reg, slot_cnt_next;
    logic [63:0]           staging_reg [FRAME_SLOTS];
    logic [USED_W-1:0]     used_reg, used_next;
    logic [ENTRY_W-1:0]    ent_reg, ent_next;
    logic [FRAME_W-1:0]    frm_reg, frm_next;
    logic [63:0]           add_reg, add_next;
    status_t               res_status_reg, res_status_next;
    logic [ENTRY_W-1:0]    res_slot_reg, res_slot_next;
    logic [63:0]           res_frame_reg, res_frame_next;
    logic [63:0]           res_count_reg, res_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]    out_slot_reg, out_slot_next;
    logic [63:0]           out_frame_reg, out_frame_next;
    logic [63:0]           out_count_reg, out_count_next;
    logic [USED_W-1:0]     out_used_reg, out_used_next;

    logic                  stage_we;
    logic [63:0]           staged;
    logic [FRAME_W-1:0]    last_cmp;
    logic [64:0]           sum;
    logic [ENTRY_W:0]      ent_inc;
    logic                  accept;

    // Slots at or above the fill count read as zero, so the staging stack
    // needs no clearing pass between samples.
    assign staged   = ({1'b0, frm_reg} < slot_cnt_reg) ? staging_reg[frm_reg] : 64'd0;
    assign last_cmp = wait_mode ? FRAME_W'(FRAME_SLOTS - 2) : FRAME_W'(FRAME_SLOTS - 1);
    assign sum      = {1'b0, count_q} + {1'b0, add_reg};
    assign ent_inc  = {1'b0, ent_reg} + 1'b1;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            staging_reg[slot_cnt_reg[FRAME_W-1:0]] <= in_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg         <= ent_next;
        frm_reg         <= frm_next;
        add_reg         <= add_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_frame_reg   <= res_frame_next;
        res_count_reg   <= res_count_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_frame_reg   <= out_frame_next;
        out_count_reg   <= out_count_next;
        out_used_reg    <= out_used_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_cnt_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_cnt_reg  <= slot_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        slot_cnt_next   = slot_cnt_reg;
        used_next       = used_reg;
        ent_next        = ent_reg;
        frm_next        = frm_reg;
        add_next        = add_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_frame_next  = res_frame_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_frame_next  = out_frame_reg;
        out_count_next  = out_count_reg;
        out_used_next   = out_used_reg;
        stage_we        = 1'b0;
        in_ready        = (state_reg == S_IDLE);
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = {used_reg[ENTRY_W-1:0], frm_reg};
        store_req.wr_data = staged;
        store_req.rd_en   = 1'b0;
        store_req.rd_addr = {ent_reg, frm_reg};
        count_req.wr_en   = 1'b0;
        count_req.addr    = ent_reg;
        count_req.wr_data = add_reg;
        count_req.rd_en   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_FRAME:
                        begin
                            if (slot_cnt_reg < SLOT_CNT_W'(FRAME_SLOTS))
                            begin
                                stage_we      = 1'b1;
                                slot_cnt_next = slot_cnt_reg + 1'b1;
                            end
                            if (in_last)
                            begin
                                add_next   = wait_mode ? in_weight : 64'd1;
                                state_next = S_FIN;
                            end
                        end
                        KIND_READ:
                        begin
                            ent_next = in_entry;
                            frm_next = in_fidx;
                            if ({1'b0, in_entry} >= used_reg)
                            begin
                                res_status_next = ST_BADIDX;
                                res_slot_next   = '0;
                                res_frame_next  = '0;
                                res_count_next  = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD_ADDR;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            used_next     = '0;
                            slot_cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                frm_next       = '0;
                ent_next       = '0;
                res_slot_next  = '0;
                res_frame_next = '0;
                res_count_next = '0;
                if (slot_cnt_reg == '0 || staging_reg[0] == 64'd0)
                begin
                    res_status_next = ST_SKIPPED;
                    slot_cnt_next   = '0;
                    state_next      = S_EMIT;
                end
                else if (used_reg == '0)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                store_req.rd_en = 1'b1;
                state_next      = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (store_q != staged)
                begin
                    frm_next = '0;
                    if ({1'b0, ent_inc} >= {1'b0, used_reg})
                    begin
                        if (used_reg >= USED_W'(TABLE_ENTRIES))
                        begin
                            res_status_next = ST_DROPPED;
                            slot_cnt_next   = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_COPY;
                        end
                    end
                    else
                    begin
                        ent_next   = ent_inc[ENTRY_W-1:0];
                        state_next = S_SCAN_RD;
                    end
                end
                else if (store_q == 64'd0 || frm_reg == last_cmp)
                begin
                    state_next = S_CNT_RD;
                end
                else
                begin
                    frm_next   = frm_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CNT_RD:
            begin
                count_req.rd_en = 1'b1;
                state_next      = S_CNT_UPD;
            end
            S_CNT_UPD:
            begin
                count_req.wr_en   = 1'b1;
                count_req.wr_data = sum[64] ? {64{1'b1}} : sum[63:0];
                res_status_next   = ST_MERGED;
                res_slot_next     = ent_reg;
                res_count_next    = count_req.wr_data;
                slot_cnt_next     = '0;
                state_next        = S_EMIT;
            end
            S_COPY:
            begin
                store_req.wr_en = 1'b1;
                frm_next        = frm_reg + 1'b1;
                if (frm_reg == FRAME_W'(FRAME_SLOTS - 1))
                begin
                    count_req.wr_en = 1'b1;
                    count_req.addr  = used_reg[ENTRY_W-1:0];
                    res_status_next = ST_ADDED;
                    res_slot_next   = used_reg[ENTRY_W-1:0];
                    res_count_next  = add_reg;
                    used_next       = used_reg + 1'b1;
                    slot_cnt_next   = '0;
                    state_next      = S_EMIT;
                end
            end
            S_RD_ADDR:
            begin
                store_req.rd_en = 1'b1;
                count_req.rd_en = 1'b1;
                state_next      = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                res_status_next = ST_READ;
                res_slot_next   = ent_reg;
                res_frame_next  = store_q;
                res_count_next  = count_q;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_frame_next  = res_frame_reg;
                    out_count_next  = res_count_reg;
                    out_used_next   = used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_frame  = out_frame_reg;
    assign out_count  = out_count_reg;
    assign out_used   = out_used_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_copy_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> used_reg < USED_W'(TABLE_ENTRIES))
        else $error("append started on a full table");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg <= SLOT_CNT_W'(FRAME_SLOTS))
        else $error("staging fill count overran");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_kind == KIND_CLEAR |=> used_reg == '0 && slot_cnt_reg == '0)
        else $error("clear did not empty the table");

endmodule
`default_nettype wire
